FILE: rtl/slx_pkg.sv
// Shared constants, types and character helpers for the script lexer.
`timescale 1ns / 1ps

package slx_pkg;

    localparam int MAX_LEXEME_DEF = 32;

    // character codes the lexer reacts to
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_AT       = 8'h40;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_EQUAL    = 8'h3D;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_POINT    = 8'h2E;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;

    // token kinds
    localparam logic [2:0] KIND_VARIABLE = 3'd0;
    localparam logic [2:0] KIND_KEYSEP   = 3'd3;
    localparam logic [2:0] KIND_STRING   = 3'd4;
    localparam logic [2:0] KIND_NUMBER   = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNEXP    = 3'd1;
    localparam logic [2:0] ST_STRING   = 3'd2;
    localparam logic [2:0] ST_NUMBER   = 3'd3;
    localparam logic [2:0] ST_KEYWORD  = 3'd4;
    localparam logic [2:0] ST_NAME     = 3'd5;
    localparam logic [2:0] ST_OVERLONG = 3'd6;

    // keyword table
    localparam int KW_COUNT = 5;
    localparam logic [2:0] KW_IF    = 3'd0;
    localparam logic [2:0] KW_THEN  = 3'd1;
    localparam logic [2:0] KW_GO    = 3'd2;
    localparam logic [2:0] KW_BEGIN = 3'd3;
    localparam logic [2:0] KW_END   = 3'd4;

    typedef struct packed {
        logic       init;   // first letter of a keyword run
        logic       step;   // further letter of a keyword run
        logic [7:0] ch;
    } kw_ctl_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [2:0] kw_len(input logic [2:0] k);
        logic [2:0] n;
        unique case (k)
            KW_IF:    n = 3'd2;
            KW_THEN:  n = 3'd4;
            KW_GO:    n = 3'd2;
            KW_BEGIN: n = 3'd5;
            KW_END:   n = 3'd3;
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        unique case (k)
            KW_IF: begin
                if (p == 3'd0) c = "i";
                if (p == 3'd1) c = "f";
            end
            KW_THEN: begin
                if (p == 3'd0) c = "t";
                if (p == 3'd1) c = "h";
                if (p == 3'd2) c = "e";
                if (p == 3'd3) c = "n";
            end
            KW_GO: begin
                if (p == 3'd0) c = "g";
                if (p == 3'd1) c = "o";
            end
            KW_BEGIN: begin
                if (p == 3'd0) c = "b";
                if (p == 3'd1) c = "e";
                if (p == 3'd2) c = "g";
                if (p == 3'd3) c = "i";
                if (p == 3'd4) c = "n";
            end
            KW_END: begin
                if (p == 3'd0) c = "e";
                if (p == 3'd1) c = "n";
                if (p == 3'd2) c = "d";
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/slx_kwmatch.sv
// Incremental keyword matcher: tracks which keywords the current letter run can still be.
`timescale 1ns / 1ps

module slx_kwmatch (
    input  logic             aclk,
    input  logic             aresetn,
    input  slx_pkg::kw_ctl_t ctl,
    output logic             match
);

    logic [slx_pkg::KW_COUNT-1:0] flags_reg, flags_next;
    logic [2:0]                   cnt_reg, cnt_next;
    logic [2:0]                   pos;

    always_comb begin
        pos        = ctl.init ? 3'd0 : cnt_reg;
        flags_next = flags_reg;
        cnt_next   = cnt_reg;
        match      = 1'b0;
        for (int k = 0; k < slx_pkg::KW_COUNT; k++) begin
            if (ctl.init || ctl.step) begin
                flags_next[k] = (ctl.init || flags_reg[k])
                              && (pos < slx_pkg::kw_len(3'(k)))
                              && (ctl.ch == slx_pkg::kw_char(3'(k), pos));
            end
            if (flags_reg[k] && cnt_reg == slx_pkg::kw_len(3'(k))) match = 1'b1;
        end
        if (ctl.init) begin
            cnt_next = 3'd1;
        end else if (ctl.step && cnt_reg != 3'd7) begin
            cnt_next = cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            flags_reg <= flags_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: rtl/script_lexer.sv
// Top level of the script lexer: lexing control, lexeme memory and output register.
`timescale 1ns / 1ps

// Usage
//   s_ channel: one source byte per request in s_tdata; s_tlast marks end of
//   source, and the byte is then ignored. s_tready is high only while the
//   lexer is waiting for a byte.
//   m_ channel: one request per lexeme character, tagged with kind (m_tuser),
//   position, line and status; m_tlast flags the final character of a token.
//   Errors give a single request with the status code, on that byte and on
//   every later one, until reset.
// Input hold and replay
//   A byte that finishes no token is taken while the lexer is idle; a
//   one-character separator also holds the input while it is sent. A
//   finished token is replayed from the lexeme memory one character at a
//   time (synchronous read, then output load). A byte that ends a token holds
//   the input until the last character is loaded, and also while it is
//   scanned again in start mode and while a separator it forms there is sent.
// Reset and stall
//   aresetn (synchronous, active low) returns to start mode, line 1, no
//   error. The lexeme memory is not cleared. When m_tready is low the output
//   register holds its request and replay waits; no input is taken meanwhile.

module script_lexer #(
    parameter int MAX_LEXEME = slx_pkg::MAX_LEXEME_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] lexeme_char, [12:8] char_index,
                                   // [28:13] line_number, [31:29] status_code
    output logic [2:0]  m_tuser,   // token_kind
    output logic        m_tlast    // last_char
);

    localparam int AW = $clog2(MAX_LEXEME);
    localparam int LW = $clog2(MAX_LEXEME + 1);

    typedef enum logic [2:0] {
        MD_START, MD_NAME, MD_NUMBER, MD_STRING, MD_COLON, MD_KEYWORD
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_PUSH, S_ONE, S_POST
    } state_t;

    // control and lexer state
    state_t        state_reg, state_next;
    mode_t         mode_reg, mode_next;
    logic [LW-1:0] len_reg, len_next;
    logic          point_reg, point_next;
    logic [1:0]    nkind_reg, nkind_next;
    logic [15:0]   line_reg, line_next;
    logic [2:0]    err_reg, err_next;
    logic          post_reg, post_next;     // byte must run again in start mode

    // replay and single-request payload
    logic [7:0]    char_reg, char_next;
    logic [2:0]    tkind_reg, tkind_next;
    logic [LW-1:0] rlen_reg, rlen_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [2:0]    one_kind_reg, one_kind_next;
    logic [7:0]    one_char_reg, one_char_next;
    logic [2:0]    one_status_reg, one_status_next;

    // output register
    logic          m_tvalid_reg, m_tvalid_next;
    logic [2:0]    out_kind_reg, out_kind_next;
    logic [7:0]    out_char_reg, out_char_next;
    logic [4:0]    out_idx_reg, out_idx_next;
    logic          out_last_reg, out_last_next;
    logic [15:0]   out_line_reg, out_line_next;
    logic [2:0]    out_status_reg, out_status_next;

    // lexeme memory
    logic [7:0]    lex_mem [MAX_LEXEME];
    logic [7:0]    rdata_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;

    // decode helpers
    logic          acc, free, out_load, start_act, last_item;
    logic [7:0]    act_ch;
    logic          append_req, emit_req, post_req, raise;
    logic [2:0]    raise_code, emit_kind;
    logic [LW-1:0] emit_len;
    logic          kw_match;
    slx_pkg::kw_ctl_t kw_ctl;

    slx_kwmatch u_kwmatch (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (kw_ctl),
        .match   (kw_match)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign acc      = s_tvalid && (state_reg == S_IDLE);
    assign free     = !m_tvalid_reg || m_tready;
    assign act_ch   = (state_reg == S_POST) ? char_reg : s_tdata;
    assign last_item = (LW'(idx_reg) + LW'(1)) == rlen_reg;

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        len_next        = len_reg;
        point_next      = point_reg;
        nkind_next      = nkind_reg;
        line_next       = line_reg;
        err_next        = err_reg;
        post_next       = post_reg;
        char_next       = char_reg;
        tkind_next      = tkind_reg;
        rlen_next       = rlen_reg;
        idx_next        = idx_reg;
        one_kind_next   = one_kind_reg;
        one_char_next   = one_char_reg;
        one_status_next = one_status_reg;
        out_kind_next   = out_kind_reg;
        out_char_next   = out_char_reg;
        out_idx_next    = out_idx_reg;
        out_last_next   = out_last_reg;
        out_line_next   = out_line_reg;
        out_status_next = out_status_reg;
        m_tvalid_next   = m_tvalid_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        waddr           = AW'(len_reg);
        wdata           = act_ch;
        out_load        = 1'b0;
        start_act       = 1'b0;
        append_req      = 1'b0;
        emit_req        = 1'b0;
        post_req        = 1'b0;
        raise           = 1'b0;
        raise_code      = slx_pkg::ST_OK;
        emit_kind       = slx_pkg::KIND_KEYSEP;
        emit_len        = len_reg;
        kw_ctl.init     = 1'b0;
        kw_ctl.step     = 1'b0;
        kw_ctl.ch       = act_ch;

        unique case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    char_next = s_tdata;
                    if (err_reg != slx_pkg::ST_OK) begin
                        raise      = 1'b1;
                        raise_code = err_reg;
                    end else if (s_tlast) begin
                        if (mode_reg != MD_START) begin
                            raise      = 1'b1;
                            raise_code = slx_pkg::ST_UNEXP;
                        end
                    end else begin
                        unique case (mode_reg)
                            MD_START: start_act = 1'b1;
                            MD_NAME: begin
                                if (slx_pkg::is_letter(s_tdata) ||
                                    slx_pkg::is_digit(s_tdata)) begin
                                    append_req = 1'b1;
                                end else if (len_reg <= LW'(1)) begin
                                    raise      = 1'b1;
                                    raise_code = slx_pkg::ST_NAME;
                                end else begin
                                    emit_req  = 1'b1;
                                    emit_kind = {1'b0, nkind_reg};
                                    post_req  = 1'b1;
                                end
                            end
                            MD_NUMBER: begin
                                if (slx_pkg::is_digit(s_tdata)) begin
                                    append_req = 1'b1;
                                end else if (s_tdata == slx_pkg::CH_POINT) begin
                                    if (point_reg) begin
                                        raise      = 1'b1;
                                        raise_code = slx_pkg::ST_NUMBER;
                                    end else begin
                                        point_next = 1'b1;
                                        append_req = 1'b1;
                                    end
                                end else if (slx_pkg::is_letter(s_tdata)) begin
                                    raise      = 1'b1;
                                    raise_code = slx_pkg::ST_NUMBER;
                                end else begin
                                    emit_req  = 1'b1;
                                    emit_kind = slx_pkg::KIND_NUMBER;
                                    post_req  = 1'b1;
                                end
                            end
                            MD_STRING: begin
                                if (s_tdata == slx_pkg::CH_NEWLINE) begin
                                    raise      = 1'b1;
                                    raise_code = slx_pkg::ST_STRING;
                                end else if (s_tdata == slx_pkg::CH_QUOTE) begin
                                    emit_req  = 1'b1;
                                    emit_kind = slx_pkg::KIND_STRING;
                                end else begin
                                    append_req = 1'b1;
                                end
                            end
                            MD_COLON: begin
                                emit_req  = 1'b1;
                                emit_kind = slx_pkg::KIND_KEYSEP;
                                if (s_tdata == slx_pkg::CH_EQUAL) begin
                                    // ":=" - take the '=' into the lexeme
                                    append_req = 1'b1;
                                    emit_len   = len_reg + LW'(1);
                                end else begin
                                    post_req = 1'b1;
                                end
                            end
                            MD_KEYWORD: begin
                                if (slx_pkg::is_letter(s_tdata)) begin
                                    append_req = 1'b1;
                                end else if (slx_pkg::is_digit(s_tdata) || !kw_match) begin
                                    raise      = 1'b1;
                                    raise_code = slx_pkg::ST_KEYWORD;
                                end else begin
                                    emit_req  = 1'b1;
                                    emit_kind = slx_pkg::KIND_KEYSEP;
                                    post_req  = 1'b1;
                                end
                            end
                            default: start_act = 1'b1;
                        endcase
                    end
                end
            end
            S_RD: begin
                mem_re     = 1'b1;
                state_next = S_PUSH;
            end
            S_PUSH: begin
                if (free) begin
                    out_load        = 1'b1;
                    out_kind_next   = tkind_reg;
                    out_char_next   = rdata_reg;
                    out_idx_next    = 5'(idx_reg);
                    out_last_next   = last_item;
                    out_status_next = slx_pkg::ST_OK;
                    if (last_item) begin
                        state_next = post_reg ? S_POST : S_IDLE;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_ONE: begin
                if (free) begin
                    out_load        = 1'b1;
                    out_kind_next   = one_kind_reg;
                    out_char_next   = one_char_reg;
                    out_idx_next    = 5'd0;
                    out_last_next   = 1'b1;
                    out_status_next = one_status_reg;
                    state_next      = post_reg ? S_POST : S_IDLE;
                end
            end
            S_POST: begin
                post_next = 1'b0;
                start_act = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase

        // add a character to the lexeme, or flag an overlong one
        if (append_req) begin
            if (len_reg >= LW'(MAX_LEXEME)) begin
                raise      = 1'b1;
                raise_code = slx_pkg::ST_OVERLONG;
            end else begin
                mem_we   = 1'b1;
                len_next = len_reg + LW'(1);
                if (mode_reg == MD_KEYWORD) kw_ctl.step = 1'b1;
            end
        end

        // finished token: replay from memory, or a lone zero for an empty string
        if (emit_req && !raise) begin
            tkind_next = emit_kind;
            len_next   = '0;
            mode_next  = MD_START;
            post_next  = post_req;
            if (emit_len == '0) begin
                one_kind_next   = emit_kind;
                one_char_next   = 8'h00;
                one_status_next = slx_pkg::ST_OK;
                state_next      = S_ONE;
            end else begin
                rlen_next  = emit_len;
                idx_next   = '0;
                state_next = S_RD;
            end
        end

        // error request; error state is sticky
        if (raise) begin
            err_next        = raise_code;
            one_kind_next   = slx_pkg::KIND_VARIABLE;
            one_char_next   = 8'h00;
            one_status_next = raise_code;
            post_next       = 1'b0;
            state_next      = S_ONE;
        end

        // start-mode handling of a byte, fresh or carried over after a token
        if (start_act) begin
            state_next = S_IDLE;
            mode_next  = MD_START;
            waddr      = '0;
            if (act_ch == slx_pkg::CH_DOLLAR || act_ch == slx_pkg::CH_QUESTION ||
                act_ch == slx_pkg::CH_AT) begin
                nkind_next = (act_ch == slx_pkg::CH_DOLLAR)   ? 2'd0 :
                             (act_ch == slx_pkg::CH_QUESTION) ? 2'd1 : 2'd2;
                mode_next  = MD_NAME;
                mem_we     = 1'b1;
                len_next   = LW'(1);
            end else if (slx_pkg::is_digit(act_ch)) begin
                point_next = 1'b0;
                mode_next  = MD_NUMBER;
                mem_we     = 1'b1;
                len_next   = LW'(1);
            end else if (act_ch == slx_pkg::CH_QUOTE) begin
                mode_next = MD_STRING;
                len_next  = '0;
            end else if (act_ch == slx_pkg::CH_COLON) begin
                mode_next = MD_COLON;
                mem_we    = 1'b1;
                len_next  = LW'(1);
            end else if (slx_pkg::is_letter(act_ch)) begin
                mode_next   = MD_KEYWORD;
                mem_we      = 1'b1;
                len_next    = LW'(1);
                kw_ctl.init = 1'b1;
            end else if (act_ch == slx_pkg::CH_NEWLINE) begin
                if (line_reg != 16'hFFFF) line_next = line_reg + 16'd1;
            end else if (act_ch != slx_pkg::CH_SPACE && act_ch != slx_pkg::CH_TAB) begin
                // one-character separator, sent straight from the byte
                len_next        = '0;
                one_kind_next   = slx_pkg::KIND_KEYSEP;
                one_char_next   = act_ch;
                one_status_next = slx_pkg::ST_OK;
                state_next      = S_ONE;
            end
        end

        if (out_load) begin
            m_tvalid_next = 1'b1;
            out_line_next = line_reg;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) lex_mem[waddr] <= wdata;
        if (mem_re) rdata_reg <= lex_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            mode_reg     <= MD_START;
            len_reg      <= '0;
            point_reg    <= 1'b0;
            nkind_reg    <= 2'd0;
            line_reg     <= 16'd1;
            err_reg      <= slx_pkg::ST_OK;
            post_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            len_reg      <= len_next;
            point_reg    <= point_next;
            nkind_reg    <= nkind_next;
            line_reg     <= line_next;
            err_reg      <= err_next;
            post_reg     <= post_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        char_reg       <= char_next;
        tkind_reg      <= tkind_next;
        rlen_reg       <= rlen_next;
        idx_reg        <= idx_next;
        one_kind_reg   <= one_kind_next;
        one_char_reg   <= one_char_next;
        one_status_reg <= one_status_next;
        out_kind_reg   <= out_kind_next;
        out_char_reg   <= out_char_next;
        out_idx_reg    <= out_idx_next;
        out_last_reg   <= out_last_next;
        out_line_reg   <= out_line_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_status_reg, out_line_reg, out_idx_reg, out_char_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: tb/slx_token_check.sv
// Checker for script_lexer: tracks the lexer state per input request and compares output requests.
`timescale 1ns / 1ps

module slx_token_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_in
    input  logic        s_tlast,    // end_of_input
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // [7:0] lexeme_char, [12:8] char_index,
                                    // [28:13] line_number, [31:29] status_code
    input  logic [2:0]  m_tuser,    // token_kind
    input  logic        m_tlast,    // last_char
    output int          fail_count,
    output int          pending
);

    localparam logic [2:0]  KIND_FUNCTION = 3'd1;
    localparam logic [2:0]  KIND_LABEL    = 3'd2;
    localparam logic [15:0] LINE_SAT      = 16'hFFFF;
    localparam int          TEXT_MAX      = slx_pkg::MAX_LEXEME_DEF;

    typedef enum logic [2:0] {
        CM_START, CM_NAME, CM_NUMBER, CM_STRING, CM_COLON, CM_KEYWORD
    } chk_mode_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  ch;
        logic [4:0]  idx;
        logic        last;
        logic [15:0] line;
        logic [2:0]  status;
    } tok_char_t;

    // lexer state as seen from the request stream
    chk_mode_t   mode;
    logic [7:0]  text [TEXT_MAX];
    int          text_len;
    bit          point;
    logic [2:0]  name_kind;
    logic [15:0] line_no;
    logic [2:0]  err;

    tok_char_t   step_chars[$];
    tok_char_t   token_chars_q[$];
    int          bad;

    function automatic bit alpha_ch(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit digit_ch(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit known_word();
        logic [39:0] w;
        w = '0;
        if (text_len > 5) return 1'b0;
        for (int i = 0; i < text_len; i++) w = {w[31:0], text[i]};
        case (text_len)
            2:       return w[15:0] == "if" || w[15:0] == "go";
            3:       return w[23:0] == "end";
            4:       return w[31:0] == "then";
            5:       return w == "begin";
            default: return 1'b0;
        endcase
    endfunction

    task automatic note_char(input logic [2:0] kind, input logic [7:0] ch, input int idx,
                             input bit last, input logic [2:0] status);
        tok_char_t e;
        e.kind   = kind;
        e.ch     = ch;
        e.idx    = idx[4:0];
        e.last   = last;
        e.line   = line_no;
        e.status = status;
        step_chars.push_back(e);
    endtask

    task automatic add_char(input logic [7:0] c);
        if (text_len >= TEXT_MAX) begin
            err = slx_pkg::ST_OVERLONG;
        end else begin
            text[text_len] = c;
            text_len++;
        end
    endtask

    task automatic flush_token(input logic [2:0] kind);
        if (text_len == 0) begin
            note_char(kind, 8'h00, 0, 1'b1, slx_pkg::ST_OK);   // empty string
        end else begin
            for (int i = 0; i < text_len; i++)
                note_char(kind, text[i], i, i == text_len - 1, slx_pkg::ST_OK);
        end
        text_len = 0;
        mode     = CM_START;
    endtask

    task automatic open_token(input chk_mode_t next_mode, input logic [7:0] c);
        mode     = next_mode;
        text_len = 0;
        add_char(c);
    endtask

    // one pass over a byte; again is set when the terminating byte must be rescanned
    task automatic lex_byte(input logic [7:0] c, output bit again);
        again = 1'b0;
        case (mode)
            CM_NAME: begin
                if (alpha_ch(c) || digit_ch(c)) add_char(c);
                else if (text_len <= 1) err = slx_pkg::ST_NAME;
                else begin
                    flush_token(name_kind);
                    again = 1'b1;
                end
            end
            CM_NUMBER: begin
                if (digit_ch(c)) begin
                    add_char(c);
                end else if (c == slx_pkg::CH_POINT) begin
                    if (point) err = slx_pkg::ST_NUMBER;
                    else begin
                        point = 1'b1;
                        add_char(c);
                    end
                end else if (alpha_ch(c)) begin
                    err = slx_pkg::ST_NUMBER;
                end else begin
                    flush_token(slx_pkg::KIND_NUMBER);
                    again = 1'b1;
                end
            end
            CM_STRING: begin
                if (c == slx_pkg::CH_NEWLINE) err = slx_pkg::ST_STRING;
                else if (c == slx_pkg::CH_QUOTE) flush_token(slx_pkg::KIND_STRING);
                else add_char(c);
            end
            CM_COLON: begin
                if (c == slx_pkg::CH_EQUAL) begin
                    add_char(c);
                    flush_token(slx_pkg::KIND_KEYSEP);
                end else begin
                    flush_token(slx_pkg::KIND_KEYSEP);
                    again = 1'b1;
                end
            end
            CM_KEYWORD: begin
                if (alpha_ch(c)) add_char(c);
                else if (digit_ch(c) || !known_word()) err = slx_pkg::ST_KEYWORD;
                else begin
                    flush_token(slx_pkg::KIND_KEYSEP);
                    again = 1'b1;
                end
            end
            default: begin
                mode = CM_START;
                if (c == slx_pkg::CH_DOLLAR || c == slx_pkg::CH_QUESTION ||
                    c == slx_pkg::CH_AT) begin
                    name_kind = (c == slx_pkg::CH_DOLLAR)   ? slx_pkg::KIND_VARIABLE :
                                (c == slx_pkg::CH_QUESTION) ? KIND_FUNCTION : KIND_LABEL;
                    open_token(CM_NAME, c);
                end else if (digit_ch(c)) begin
                    point = 1'b0;
                    open_token(CM_NUMBER, c);
                end else if (c == slx_pkg::CH_QUOTE) begin
                    mode     = CM_STRING;
                    text_len = 0;
                end else if (c == slx_pkg::CH_COLON) begin
                    open_token(CM_COLON, c);
                end else if (alpha_ch(c)) begin
                    open_token(CM_KEYWORD, c);
                end else if (c == slx_pkg::CH_NEWLINE) begin
                    if (line_no != LINE_SAT) line_no++;
                end else if (c != slx_pkg::CH_SPACE && c != slx_pkg::CH_TAB) begin
                    text_len = 0;
                    add_char(c);
                    flush_token(slx_pkg::KIND_KEYSEP);
                end
            end
        endcase
    endtask

    task automatic lex_request(input logic [7:0] c, input logic eoi);
        bit again;
        step_chars.delete();
        if (err == slx_pkg::ST_OK && eoi) begin
            if (mode == CM_START) return;
            err = slx_pkg::ST_UNEXP;
        end
        if (err == slx_pkg::ST_OK) begin
            lex_byte(c, again);
            if (again && err == slx_pkg::ST_OK) lex_byte(c, again);
        end
        // sticky error: a single status request replaces any token output
        if (err != slx_pkg::ST_OK) begin
            step_chars.delete();
            note_char(slx_pkg::KIND_VARIABLE, 8'h00, 0, 1'b1, err);
        end
        foreach (step_chars[i]) token_chars_q.push_back(step_chars[i]);
    endtask

    task automatic check_field(input string label, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $error("%s mismatch: expected 'h%0h, got 'h%0h", label, want_v, got_v);
            bad++;
        end
    endtask

    always @(posedge aclk) begin
        tok_char_t want;
        if (!aresetn) begin
            mode      = CM_START;
            text_len  = 0;
            point     = 1'b0;
            name_kind = slx_pkg::KIND_VARIABLE;
            line_no   = 16'd1;
            err       = slx_pkg::ST_OK;
            bad       = 0;
            token_chars_q.delete();
        end else begin
            // outputs first: an output taken at this edge always stems from older input
            if (m_tvalid && m_tready) begin
                if (token_chars_q.size() == 0) begin
                    $error("output request with nothing expected: char 'h%0h status %0d",
                           m_tdata[7:0], m_tdata[31:29]);
                    bad++;
                end else begin
                    want = token_chars_q.pop_front();
                    check_field("token_kind",  want.kind,   m_tuser);
                    check_field("lexeme_char", want.ch,     m_tdata[7:0]);
                    check_field("char_index",  want.idx,    m_tdata[12:8]);
                    check_field("last_char",   want.last,   m_tlast);
                    check_field("line_number", want.line,   m_tdata[28:13]);
                    check_field("status_code", want.status, m_tdata[31:29]);
                end
            end
            if (s_tvalid && s_tready) lex_request(s_tdata, s_tlast);
        end
        pending    <= token_chars_q.size();
        fail_count <= bad;
    end

endmodule

FILE: tb/tb_script_lexer.sv
// Testbench top for script_lexer: source byte stimulus, output back-pressure and the verdict.
`timescale 1ns / 1ps

module tb_script_lexer;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_ITEMS = 280;
    localparam int IDLE_PCT     = 28;
    localparam int HOLD_CYCLES  = 400;         // long receiver hold-off
    localparam int SETTLE       = 40;          // covers replay latency after the last request

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int          fail_count;
    int          pending;

    // stimulus control
    bit          gaps_on    = 1'b1;   // sender idles at random
    bit          stalls_on  = 1'b1;   // receiver drops m_tready at random
    int          hold_asks  = 0;      // bumped by stimulus to ask for a long hold-off
    int          holds_done = 0;      // bumped by the receiver when one is served
    bit          tail_open  = 1'b0;   // a name, number, keyword or lone ':' is still open
    int          items_sent = 0;
    int unsigned cycle_count = 0;

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    script_lexer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    slx_token_check u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("script_lexer verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off counted here while the sender
    // keeps offering requests, so replay backs up and s_tready stays low.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_asks != holds_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_done++;
            end else begin
                m_tready <= !(stalls_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Character classes for building well-formed source text
    // ---------------------------------------------------------------------

    function automatic bit sep_ok(input logic [7:0] c);
        // bytes that form a one-character separator in start mode; '.' is left
        // out so that it never extends a number that precedes it
        return !(slx_pkg::is_letter(c) || slx_pkg::is_digit(c)) &&
               !(c inside {slx_pkg::CH_DOLLAR, slx_pkg::CH_QUESTION, slx_pkg::CH_AT,
                           slx_pkg::CH_QUOTE, slx_pkg::CH_COLON, slx_pkg::CH_POINT,
                           slx_pkg::CH_NEWLINE, slx_pkg::CH_SPACE, slx_pkg::CH_TAB});
    endfunction

    function automatic logic [7:0] sep_char();
        logic [7:0] c;
        do c = 8'($urandom); while (!sep_ok(c));
        return c;
    endfunction

    function automatic logic [7:0] str_byte();
        logic [7:0] c;
        do c = 8'($urandom); while (c == slx_pkg::CH_QUOTE || c == slx_pkg::CH_NEWLINE);
        return c;
    endfunction

    function automatic logic [7:0] digit_char();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] alnum_char();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10) return 8'("0" + r);
        if (r < 36) return 8'("a" + r - 10);
        return 8'("A" + r - 36);
    endfunction

    function automatic logic [7:0] space_char();
        case ($urandom_range(0, 2))
            0:       return slx_pkg::CH_SPACE;
            1:       return slx_pkg::CH_TAB;
            default: return slx_pkg::CH_NEWLINE;
        endcase
    endfunction

    function automatic string pick_keyword();
        case ($urandom_range(0, 4))
            0:       return "if";
            1:       return "then";
            2:       return "go";
            3:       return "begin";
            default: return "end";
        endcase
    endfunction

    // mostly short lexemes, now and then up to the full buffer
    function automatic int run_len(input int lo, input int hi);
        if ($urandom_range(0, 99) < 12) return $urandom_range(lo, hi);
        return $urandom_range(lo, (lo + 5 < hi) ? lo + 5 : hi);
    endfunction

    // ---------------------------------------------------------------------
    // Request driving
    // ---------------------------------------------------------------------

    // One source request; returns in the time step of the accepting edge.
    task automatic send_char(input logic [7:0] c, input logic eoi = 1'b0);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);   // junk while idle must be ignored
            s_tlast  <= 1'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eoi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_char(txt[i]);
    endtask

    task automatic send_break();
        if ($urandom_range(0, 1)) send_char(space_char());
        else send_char(sep_char());
    endtask

    // Stop offering and wait for every expected output request.
    // The extra edge lets the checker count a request taken at the last edge.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // One random well-formed token (or blank / end mark), with content random.
    task automatic random_token();
        int pick;
        int n;
        bit dot;
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            // name: sigil plus 1..31 letters/digits
            case ($urandom_range(0, 2))
                0:       send_char(slx_pkg::CH_DOLLAR);
                1:       send_char(slx_pkg::CH_QUESTION);
                default: send_char(slx_pkg::CH_AT);
            endcase
            n = run_len(1, slx_pkg::MAX_LEXEME_DEF - 1);
            repeat (n) send_char(alnum_char());
            tail_open = 1'b1;
        end else if (pick < 34) begin
            // number, at most one point
            if (tail_open) send_break();
            send_char(digit_char());
            n   = run_len(0, slx_pkg::MAX_LEXEME_DEF - 1);
            dot = 1'b0;
            repeat (n) begin
                if (!dot && $urandom_range(0, 5) == 0) begin
                    send_char(slx_pkg::CH_POINT);
                    dot = 1'b1;
                end else begin
                    send_char(digit_char());
                end
            end
            tail_open = 1'b1;
        end else if (pick < 50) begin
            // string, possibly empty, any byte but quote and newline
            send_char(slx_pkg::CH_QUOTE);
            n = run_len(0, slx_pkg::MAX_LEXEME_DEF);
            repeat (n) send_char(str_byte());
            send_char(slx_pkg::CH_QUOTE);
            tail_open = 1'b0;
        end else if (pick < 58) begin
            send_char(slx_pkg::CH_COLON);
            if ($urandom_range(0, 1)) begin
                send_char(slx_pkg::CH_EQUAL);
                tail_open = 1'b0;
            end else begin
                tail_open = 1'b1;
            end
        end else if (pick < 72) begin
            if (tail_open) send_break();
            send_text(pick_keyword());
            tail_open = 1'b1;
        end else if (pick < 86) begin
            send_char(sep_char());
            tail_open = 1'b0;
        end else begin
            // blanks, now and then an end mark between tokens (no output)
            if (tail_open) send_break();
            if ($urandom_range(0, 9) == 0) send_char(8'($urandom), 1'b1);
            else send_char(space_char());
            tail_open = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------------
    // Stimulus and verdict
    // ---------------------------------------------------------------------

    initial begin
        int         rand_goal;
        logic [2:0] err_pick;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: all token kinds, lone ':' followed by a token, ':=',
        // all keywords, numbers with a point one after another, empty string
        send_text("$a ?f1 @L9z\t:go :;:= if then go begin end\n7.5 3.1 12,\"\" ");
        // start-mode separators incl. '.', '=', NUL and high bytes
        send_char(slx_pkg::CH_POINT);
        send_char(slx_pkg::CH_EQUAL);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h80);
        // end mark in start mode: ignored
        send_char(8'h5A, 1'b1);
        // full-length string: indices up to 31
        send_char(slx_pkg::CH_QUOTE);
        send_char(8'hFF);
        send_char(8'h00);
        repeat (slx_pkg::MAX_LEXEME_DEF - 2) send_char(str_byte());
        send_char(slx_pkg::CH_QUOTE);
        // full-length name
        send_char(slx_pkg::CH_AT);
        repeat (slx_pkg::MAX_LEXEME_DEF - 1) send_char(alnum_char());
        send_char(slx_pkg::CH_SPACE);
        drain();

        // Random token stream with a quiet stretch, a long receiver hold-off
        // and a sender pause until everything is out.
        rand_goal = items_sent + RANDOM_ITEMS;
        for (int t = 0; items_sent < rand_goal; t++) begin
            if (t == 8) begin
                gaps_on = 1'b0;
                stalls_on <= 1'b0;
            end
            if (t == 24) begin
                gaps_on = 1'b1;
                stalls_on <= 1'b1;
            end
            if (t == 32) hold_asks <= hold_asks + 1;
            if (t == 44) drain();
            random_token();
        end

        // Tokens across a line break
        send_text("$top\n?x ");
        tail_open = 1'b0;

        // One error kind per run (sticky until reset), then more requests
        // including an end mark, all of which must repeat the error status.
        send_char(slx_pkg::CH_SPACE);
        err_pick = 3'($urandom_range(slx_pkg::ST_UNEXP, slx_pkg::ST_OVERLONG));
        case (err_pick)
            slx_pkg::ST_UNEXP: begin
                send_text("$ab");
                send_char(8'($urandom), 1'b1);
            end
            slx_pkg::ST_STRING:   send_text("\"ab\ncd\"");
            slx_pkg::ST_NUMBER: begin
                if ($urandom_range(0, 1)) send_text("1.2.3 ");
                else send_text("12a ");
            end
            slx_pkg::ST_KEYWORD: begin
                if ($urandom_range(0, 1)) send_text("if3 ");
                else send_text("hello ");
            end
            slx_pkg::ST_NAME:     send_text("@ x");
            default: begin
                // one character past the lexeme buffer
                send_char(slx_pkg::CH_QUOTE);
                repeat (slx_pkg::MAX_LEXEME_DEF + 1) send_char(str_byte());
            end
        endcase
        repeat (4) send_char(8'($urandom));
        send_char(8'($urandom), 1'b1);
        send_char("A");

        drain();
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0) begin
            $display("script_lexer verification clean");
        end else begin
            $display("script_lexer verification failed");
        end
        $finish;
    end

endmodule
